>>> sv/pcm_pkg.sv
// Shared types and constants for the PWM capture / median filter block.
// No dependencies; used by pwm_capture_median.
package pcm_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_RD_I,
      ST_LD_I,
      ST_SCAN,
      ST_EVAL,
      ST_DONE
   } state_type;

   localparam logic [1:0] CMD_PIN   = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_TICK   = 2'd1;
   localparam logic [1:0] REG_STOP   = 2'd2;

   localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
   localparam logic [31:0] NS_PER_MS = 32'd1_000_000;

   localparam logic [6:0] WINDOW_RESET = 7'd3;
   localparam logic [9:0] TICK_MIN     = 10'd10;
   localparam logic [9:0] MS_MAX       = 10'd1000;
   localparam logic [9:0] STOP_MIN     = 10'd1;
   localparam logic [31:0] TICK_NS_RESET = 32'd10_000_000;
   localparam logic [31:0] STOP_NS_RESET = 32'd30_000_000;

endpackage

>>> sv/pcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> sv/pwm_capture_median.sv
// PWM input capture with median filtering, one pin channel (top level).
// Depends on pcm_pkg and pcm_ram.
//
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_cmd, req_timestamp_ns, req_level
// rsp      out        rsp_valid/rsp_stall   rsp_duty_ns, rsp_cycle_ns, rsp_stopped
// csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// Sequencing: a tick, an ignored pin event or cmd 3 completes in the idle state;
// a level change first takes the elapsed time, then does the ring write. A query
// on a running channel ranks every window entry against every other through the
// one RAM read port, the high ring first, then the low ring; worst case both
// rings are fully scanned. A stopped query goes straight to the result state.
// Reset: synchronous; rings read as zero via per-entry valid bits, no sweep.
// Stalls: a held result does not block new transfers; only a finished query
// waits for the result register to free up.
module pwm_capture_median #(
   parameter int MAX_WINDOW = 64,
   parameter int TIME_BITS  = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [TIME_BITS-1:0] req_timestamp_ns,
   input  logic                 req_level,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_duty_ns,
   output logic [31:0]          rsp_cycle_ns,
   output logic                 rsp_stopped,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_wdata
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int ADR_W = IDX_W + 1;
   localparam int DEPTH = 2 ** ADR_W;
   localparam logic [6:0] WIN_MAX = 7'(MAX_WINDOW);

   pcm_pkg::state_type state_ff, state_in;

   // configuration
   logic [6:0]  win_ff, win_in;
   logic [31:0] tick_ns_ff, tick_ns_in;
   logic [31:0] stop_ns_ff, stop_ns_in;

   // channel state
   logic                 pin_ff, pin_in;
   logic                 stopped_ff, stopped_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [31:0]          carried_ff, carried_in;
   logic [IDX_W-1:0]     hslot_ff, hslot_in;
   logic [IDX_W-1:0]     lslot_ff, lslot_in;
   logic [DEPTH-1:0]     valid_ff, valid_in;

   // sequencer datapath
   logic        ring_ff, ring_in;       // 0 high ring, 1 low ring
   logic [31:0] elap_ff, elap_in;
   logic [6:0]  i_ff, i_in;
   logic [6:0]  j_ff, j_in;
   logic        cmp_vld_ff, cmp_vld_in;
   logic [31:0] cand_ff, cand_in;
   logic [6:0]  less_ff, less_in;
   logic [6:0]  nm_ff, nm_in;
   logic [31:0] hi_ff, hi_in;
   logic [31:0] res_duty_ff, res_duty_in;
   logic [31:0] res_cycle_ff, res_cycle_in;
   logic        res_stop_ff, res_stop_in;
   logic        rvld_ff, rvld_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_duty_ff, rsp_duty_in;
   logic [31:0] rsp_cycle_ff, rsp_cycle_in;
   logic        rsp_stop_ff, rsp_stop_in;

   // RAM port
   logic             ram_we;
   logic [ADR_W-1:0] ram_waddr;
   logic [31:0]      ram_wdata;
   logic [ADR_W-1:0] ram_raddr;
   logic [31:0]      ram_rdata;

   logic                 req_xfer, csr_xfer, rsp_free;
   logic [TIME_BITS-1:0] diff;
   logic [31:0]          elapsed;
   logic [32:0]          tick_sum;
   logic [31:0]          tick_sat;
   logic [32:0]          edge_sum;
   logic [32:0]          cyc_sum;
   logic [31:0]          rd_word;
   logic [6:0]           k_rank;
   logic                 found;
   logic [IDX_W-1:0]     cur_slot, slot_next;
   logic [6:0]           slot_inc;
   logic [9:0]           wd_tick, wd_stop;
   logic [6:0]           wd_win;

   assign req_xfer  = req_valid && !req_stall;
   assign csr_xfer  = csr_valid && csr_ready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != pcm_pkg::ST_IDLE);
   assign csr_ready = (state_ff == pcm_pkg::ST_IDLE);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_duty_ns  = rsp_duty_ff;
   assign rsp_cycle_ns = rsp_cycle_ff;
   assign rsp_stopped  = rsp_stop_ff;

   // time since last edge or tick, modulo wrap, saturated
   assign diff    = req_timestamp_ns - last_ff;
   assign elapsed = (diff > TIME_BITS'(pcm_pkg::SAT32)) ? pcm_pkg::SAT32 : diff[31:0];

   assign tick_sum = {1'b0, carried_ff} + {1'b0, tick_ns_ff};
   assign tick_sat = tick_sum[32] ? pcm_pkg::SAT32 : tick_sum[31:0];
   assign edge_sum = {1'b0, elap_ff} + {1'b0, carried_ff};
   assign cyc_sum  = {1'b0, hi_ff} + {1'b0, cand_ff};

   // never-written entries read as zero
   assign rd_word = rvld_ff ? ram_rdata : '0;
   assign k_rank  = win_ff >> 1;
   assign found   = (less_ff <= k_rank) && (k_rank < nm_ff);

   // ring slot advance
   always_comb begin
      cur_slot = ring_ff ? lslot_ff : hslot_ff;
      if ({1'b0, cur_slot} >= ADR_W'(MAX_WINDOW)) begin
         cur_slot = '0;
      end
      slot_inc = 7'(cur_slot) + 7'd1;
      slot_next = (slot_inc >= win_ff) ? '0 : IDX_W'(slot_inc);
   end

   // register value clamps
   always_comb begin
      wd_win = csr_wdata[6:0];
      if (wd_win < 7'd1) begin
         wd_win = 7'd1;
      end else if (wd_win > WIN_MAX) begin
         wd_win = WIN_MAX;
      end
      wd_tick = csr_wdata;
      if (wd_tick < pcm_pkg::TICK_MIN) begin
         wd_tick = pcm_pkg::TICK_MIN;
      end else if (wd_tick > pcm_pkg::MS_MAX) begin
         wd_tick = pcm_pkg::MS_MAX;
      end
      wd_stop = csr_wdata;
      if (wd_stop < pcm_pkg::STOP_MIN) begin
         wd_stop = pcm_pkg::STOP_MIN;
      end else if (wd_stop > pcm_pkg::MS_MAX) begin
         wd_stop = pcm_pkg::MS_MAX;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_cmd == pcm_pkg::CMD_PIN && req_level != pin_ff) begin
                  state_in = pcm_pkg::ST_EDGE;
               end else if (req_cmd == pcm_pkg::CMD_QUERY) begin
                  state_in = stopped_ff ? pcm_pkg::ST_DONE : pcm_pkg::ST_RD_I;
               end
            end
         end
         pcm_pkg::ST_EDGE: state_in = pcm_pkg::ST_IDLE;
         pcm_pkg::ST_RD_I: state_in = pcm_pkg::ST_LD_I;
         pcm_pkg::ST_LD_I: state_in = pcm_pkg::ST_SCAN;
         pcm_pkg::ST_SCAN: begin
            if (j_ff >= win_ff && !cmp_vld_ff) begin
               state_in = pcm_pkg::ST_EVAL;
            end
         end
         pcm_pkg::ST_EVAL: begin
            if (found && ring_ff) begin
               state_in = pcm_pkg::ST_DONE;
            end else begin
               state_in = pcm_pkg::ST_RD_I;
            end
         end
         pcm_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = pcm_pkg::ST_IDLE;
            end
         end
         default: state_in = pcm_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      win_in       = win_ff;
      tick_ns_in   = tick_ns_ff;
      stop_ns_in   = stop_ns_ff;
      pin_in       = pin_ff;
      stopped_in   = stopped_ff;
      last_in      = last_ff;
      carried_in   = carried_ff;
      hslot_in     = hslot_ff;
      lslot_in     = lslot_ff;
      valid_in     = valid_ff;
      ring_in      = ring_ff;
      elap_in      = elap_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cmp_vld_in   = 1'b0;
      cand_in      = cand_ff;
      less_in      = less_ff;
      nm_in        = nm_ff;
      hi_in        = hi_ff;
      res_duty_in  = res_duty_ff;
      res_cycle_in = res_cycle_ff;
      res_stop_in  = res_stop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_duty_in  = rsp_duty_ff;
      rsp_cycle_in = rsp_cycle_ff;
      rsp_stop_in  = rsp_stop_ff;
      ram_we       = 1'b0;
      ram_waddr    = {ring_ff, cur_slot};
      ram_wdata    = edge_sum[32] ? pcm_pkg::SAT32 : edge_sum[31:0];
      ram_raddr    = {ring_ff, i_ff[IDX_W-1:0]};

      case (state_ff)
         pcm_pkg::ST_IDLE: begin
            if (csr_xfer) begin
               case (csr_index)
                  pcm_pkg::REG_WINDOW: win_in = wd_win;
                  pcm_pkg::REG_TICK:   tick_ns_in = 32'(32'(wd_tick) * pcm_pkg::NS_PER_MS);
                  pcm_pkg::REG_STOP:   stop_ns_in = 32'(32'(wd_stop) * pcm_pkg::NS_PER_MS);
                  default: ;
               endcase
               if (csr_index == pcm_pkg::REG_WINDOW || csr_index == pcm_pkg::REG_TICK) begin
                  valid_in   = '0;
                  hslot_in   = '0;
                  lslot_in   = '0;
                  last_in    = '0;
                  carried_in = '0;
                  stopped_in = 1'b1;
               end
            end
            if (req_xfer) begin
               case (req_cmd)
                  pcm_pkg::CMD_PIN: begin
                     if (req_level != pin_ff) begin
                        pin_in     = req_level;
                        ring_in    = req_level;
                        elap_in    = stopped_ff ? '0 : elapsed;
                        stopped_in = 1'b0;
                        last_in    = req_timestamp_ns;
                     end
                  end
                  pcm_pkg::CMD_TICK: begin
                     if (!stopped_ff) begin
                        if (carried_ff != '0) begin
                           if (tick_sat > stop_ns_ff) begin
                              valid_in   = '0;
                              hslot_in   = '0;
                              lslot_in   = '0;
                              last_in    = '0;
                              carried_in = '0;
                              stopped_in = 1'b1;
                              pin_in     = req_level;
                           end else begin
                              carried_in = tick_sat;
                              last_in    = req_timestamp_ns;
                           end
                        end else begin
                           carried_in = elapsed;
                           last_in    = req_timestamp_ns;
                        end
                     end
                  end
                  pcm_pkg::CMD_QUERY: begin
                     ring_in      = 1'b0;
                     i_in         = '0;
                     res_duty_in  = '0;
                     res_cycle_in = '0;
                     res_stop_in  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         pcm_pkg::ST_EDGE: begin
            ram_we     = 1'b1;
            valid_in[{ring_ff, cur_slot}] = 1'b1;
            carried_in = '0;
            if (ring_ff) begin
               lslot_in = slot_next;
            end else begin
               hslot_in = slot_next;
            end
         end
         pcm_pkg::ST_RD_I: begin
            ram_raddr = {ring_ff, i_ff[IDX_W-1:0]};
         end
         pcm_pkg::ST_LD_I: begin
            cand_in = rd_word;
            less_in = '0;
            nm_in   = '0;
            j_in    = '0;
         end
         pcm_pkg::ST_SCAN: begin
            ram_raddr = {ring_ff, j_ff[IDX_W-1:0]};
            if (j_ff < win_ff) begin
               j_in       = j_ff + 7'd1;
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff) begin
               less_in = less_ff + 7'(rd_word < cand_ff);
               nm_in   = nm_ff + 7'(rd_word <= cand_ff);
            end
         end
         pcm_pkg::ST_EVAL: begin
            if (found) begin
               i_in = '0;
               if (!ring_ff) begin
                  hi_in   = cand_ff;
                  ring_in = 1'b1;
               end else begin
                  res_duty_in  = hi_ff;
                  res_cycle_in = cyc_sum[32] ? pcm_pkg::SAT32 : cyc_sum[31:0];
                  res_stop_in  = 1'b0;
               end
            end else begin
               i_in = i_ff + 7'd1;
            end
         end
         pcm_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in  = res_duty_ff;
               rsp_cycle_in = res_cycle_ff;
               rsp_stop_in  = res_stop_ff;
            end
         end
         default: ;
      endcase

      rvld_in = valid_ff[ram_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcm_pkg::ST_IDLE;
         win_ff       <= pcm_pkg::WINDOW_RESET;
         tick_ns_ff   <= pcm_pkg::TICK_NS_RESET;
         stop_ns_ff   <= pcm_pkg::STOP_NS_RESET;
         pin_ff       <= 1'b0;
         stopped_ff   <= 1'b1;
         last_ff      <= '0;
         carried_ff   <= '0;
         hslot_ff     <= '0;
         lslot_ff     <= '0;
         valid_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         tick_ns_ff   <= tick_ns_in;
         stop_ns_ff   <= stop_ns_in;
         pin_ff       <= pin_in;
         stopped_ff   <= stopped_in;
         last_ff      <= last_in;
         carried_ff   <= carried_in;
         hslot_ff     <= hslot_in;
         lslot_ff     <= lslot_in;
         valid_ff     <= valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ring_ff      <= ring_in;
      elap_ff      <= elap_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      cand_ff      <= cand_in;
      less_ff      <= less_in;
      nm_ff        <= nm_in;
      hi_ff        <= hi_in;
      res_duty_ff  <= res_duty_in;
      res_cycle_ff <= res_cycle_in;
      res_stop_ff  <= res_stop_in;
      rvld_ff      <= rvld_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_cycle_ff <= rsp_cycle_in;
      rsp_stop_ff  <= rsp_stop_in;
   end

   // both rings share one RAM, ring select is the top address bit
   pcm_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ring_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
